// File: sv/masked_laplacian_stencil_assert.svh
// assertion macros for the masked laplacian stencil
`ifndef MASKED_LAPLACIAN_STENCIL_ASSERT_SVH
`define MASKED_LAPLACIAN_STENCIL_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MLS_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mls assertion failed");

// next-cycle implication
`define MLS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mls assertion failed");

`endif

// File: sv/mls_pkg.sv
// shared types, constants and helpers for the masked laplacian stencil
`timescale 1ns / 1ps
`default_nettype none

package mls_pkg;

  localparam int MAX_EXTENT = 32;
  localparam int NUM_AXES   = 3;
  localparam int FRAC_BITS  = 16;

  localparam int COORD_W   = 5;
  localparam int SIZE_W    = 6;
  localparam int WEIGHT_W  = 32;
  localparam int VALUE_W   = 32;
  localparam int OUT_W     = 48;
  localparam int ADDR_W    = NUM_AXES * COORD_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int HALF_W    = WEIGHT_W / 2;
  localparam int DIFF_W    = VALUE_W + 3;
  localparam int PROD_W    = DIFF_W + HALF_W + 1;
  localparam int ACC_W     = DIFF_W + WEIGHT_W + 3;
  localparam int NUM_SLOTS = 2 * NUM_AXES + 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int NUM_STEPS = 2 * NUM_AXES;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam int AXIS_W    = $clog2(NUM_AXES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Z = 3'd5;

  localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(MAX_EXTENT);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1) << FRAC_BITS;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [OUT_W-1:0] SAT_HIGH = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_LOW  = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic                      operation;
    logic [COORD_W-1:0]        coord_x;
    logic [COORD_W-1:0]        coord_y;
    logic [COORD_W-1:0]        coord_z;
    logic signed [VALUE_W-1:0] voxel_value;
    logic                      in_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] laplacian;
    logic                    inside_res;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              clr_we;
    logic              wr_en;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              mul_en;
    logic [STEP_W-1:0] mul_step;
    logic              fin_en;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

  // zero reads as one, anything above the grid limit as the limit
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] s;
    if (r == '0) s = SIZE_W'(1);
    else if (r > SIZE_W'(MAX_EXTENT)) s = SIZE_W'(MAX_EXTENT);
    else s = r;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/masked_laplacian_stencil.sv
// Masked seven-point Laplacian over a voxel memory. After reset the block
// clears all 32768 entries of the mask memory, one entry per cycle, with busy high;
// configuration writes are taken during that time. An item is taken when start
// is high and busy is low. A load writes both memories, if its coordinates lie
// in the grid, and gives no result. A query makes seven reads through the
// single read port of the voxel memory (centre and six neighbours), six steps
// of one 16 x 35 bit multiplier, then accumulate and saturate. Its result is
// driven on out_result with out_strobe high for one cycle, while busy is
// already low; the receiver has no way to stall it and must take it then.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_laplacian_stencil_assert.svh"

module masked_laplacian_stencil import mls_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_strobe,
  output out_item_t                  out_result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_item.operation),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  `MLS_ASSERT_IMPL(a_strobe_idle, out_strobe, !busy)
  `MLS_ASSERT_NEXT(a_single_beat, out_strobe, !out_strobe)
  `MLS_ASSERT_IMPL(a_outside_zero, out_strobe && !out_result.inside_res, out_result.laplacian == '0)
  `MLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

`default_nettype wire

// File: sv/mls_ctrl.sv
// controller state machine: clear sweep, load write, read slots, multiply steps
`timescale 1ns / 1ps
`default_nettype none

module mls_ctrl import mls_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       in_op,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_ACC   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          slot_nxt    = '0;
          state_nxt   = (in_op == OP_QUERY) ? ST_READ : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_slot = slot_r;
        if (slot_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = step_r;
        if (step_r == STEP_W'(NUM_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_ACC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      slot_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/mls_dp.sv
// datapath: config registers, voxel and mask memories, accumulate, multiply, saturate
`timescale 1ns / 1ps
`default_nettype none

module mls_dp import mls_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_item,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_strobe,
  output out_item_t                  out_result
);

  logic [SIZE_W-1:0]   size_r   [NUM_AXES];
  logic [WEIGHT_W-1:0] weight_r [NUM_AXES];

  in_item_t item_r;

  logic [VALUE_W-1:0] value_mem [DEPTH];
  logic               mask_mem  [DEPTH];

  logic signed [VALUE_W-1:0] val_q;
  logic                      msk_q;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] centre_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] stride;
  logic [SLOT_W-1:0] rd_nb;
  logic [AXIS_W-1:0] rd_axis;

  logic [COORD_W-1:0] coord [NUM_AXES];
  logic [SIZE_W-1:0]  eff   [NUM_AXES];
  logic               in_grid;

  logic              cap_vld_r;
  logic [SLOT_W-1:0] cap_slot_r;
  logic [SLOT_W-1:0] cap_nb;
  logic [AXIS_W-1:0] cap_axis;
  logic              cap_ok;

  logic                     centre_mask_r;
  logic signed [DIFF_W-1:0] diff_r [NUM_AXES];
  logic signed [DIFF_W-1:0] val_ext;

  logic [AXIS_W-1:0]        mul_axis;
  logic [HALF_W-1:0]        w_part;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic                     prod_hi_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [ACC_W-1:0]     shifted;
  logic [ACC_W-OUT_W:0]        top_bits;
  logic signed [OUT_W-1:0]     lap_sat;
  logic                        centre_in;

  logic      out_vld_r;
  out_item_t out_item_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        size_r[a]   <= SIZE_RESET;
        weight_r[a] <= WEIGHT_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X:   size_r[0]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:   size_r[1]   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:   size_r[2]   <= cfg_data[SIZE_W-1:0];
        CFG_WEIGHT_X: weight_r[0] <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_Y: weight_r[1] <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_Z: weight_r[2] <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
  end

  assign coord[0] = item_r.coord_x;
  assign coord[1] = item_r.coord_y;
  assign coord[2] = item_r.coord_z;

  always_comb begin
    in_grid = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      eff[a] = eff_size(size_r[a]);
      if (SIZE_W'(coord[a]) >= eff[a]) in_grid = 1'b0;
    end
  end

  // read address: centre, then minus and plus neighbour per axis
  assign centre_addr = {item_r.coord_z, item_r.coord_y, item_r.coord_x};

  always_comb begin
    rd_nb   = cmd.rd_slot - SLOT_W'(1);
    rd_axis = AXIS_W'(rd_nb >> 1);
    stride  = ADDR_W'(1) << (rd_axis * COORD_W);
    if (cmd.rd_slot == '0) rd_addr = centre_addr;
    else if (rd_nb[0]) rd_addr = centre_addr + stride;
    else rd_addr = centre_addr - stride;
  end

  // clear sweep over the mask memory
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_we) clr_addr_r <= clr_addr_r + ADDR_W'(1);
  end

  assign status.clr_last = (clr_addr_r == '1);

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mask_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.wr_en && in_grid) begin
      mask_mem[centre_addr] <= item_r.in_mask;
    end
    if (cmd.rd_en) msk_q <= mask_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_grid) value_mem[centre_addr] <= item_r.voxel_value;
    if (cmd.rd_en) val_q <= value_mem[rd_addr];
  end

  // read beat tag
  always_ff @(posedge clk) begin
    if (!rst_n) cap_vld_r <= 1'b0;
    else cap_vld_r <= cmd.rd_en;
    cap_slot_r <= cmd.rd_slot;
  end

  always_comb begin
    cap_nb   = cap_slot_r - SLOT_W'(1);
    cap_axis = AXIS_W'(cap_nb >> 1);
    if (cap_nb[0]) cap_ok = (SIZE_W'(coord[cap_axis]) + SIZE_W'(1)) < eff[cap_axis];
    else cap_ok = (coord[cap_axis] != '0);
  end

  assign val_ext = DIFF_W'(val_q);

  // per-axis sum left + right - 2*centre, a neighbour counting only if in the grid and masked
  always_ff @(posedge clk) begin
    if (cap_vld_r) begin
      if (cap_slot_r == '0) begin
        centre_mask_r <= msk_q;
        for (int a = 0; a < NUM_AXES; a++) diff_r[a] <= -(val_ext + val_ext);
      end else if (cap_ok && msk_q) begin
        diff_r[cap_axis] <= diff_r[cap_axis] + val_ext;
      end
    end
  end

  // weight split in halves, one half per multiply step
  always_comb begin
    mul_axis = AXIS_W'(cmd.mul_step >> 1);
    if (cmd.mul_step[0]) w_part = weight_r[mul_axis][HALF_W-1:0];
    else w_part = weight_r[mul_axis][WEIGHT_W-1:HALF_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prod_vld_r <= 1'b0;
    else prod_vld_r <= cmd.mul_en;
    prod_hi_r <= ~cmd.mul_step[0];
    prod_r    <= $signed({1'b0, w_part}) * diff_r[mul_axis];
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    if (prod_hi_r) prod_ext = prod_ext <<< HALF_W;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) acc_r <= '0;
    else if (prod_vld_r) acc_r <= acc_r + prod_ext;
  end

  // floor shift and saturate
  always_comb begin
    shifted  = acc_r >>> FRAC_BITS;
    top_bits = shifted[ACC_W-1:OUT_W-1];
    if ((&top_bits) || !(|top_bits)) lap_sat = shifted[OUT_W-1:0];
    else if (shifted[ACC_W-1]) lap_sat = SAT_LOW;
    else lap_sat = SAT_HIGH;
    centre_in = in_grid && centre_mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= cmd.fin_en;
    if (cmd.fin_en) begin
      out_item_r.laplacian  <= centre_in ? lap_sat : '0;
      out_item_r.inside_res <= centre_in;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_result = out_item_r;

endmodule

`default_nettype wire
